@@ sv/imp_pkg.sv @@
`timescale 1ns / 1ps

package imp_pkg;

   // defaults for the top-level parameters
   localparam int DEF_WEIGHT_Q16 = 655;
   localparam int DEF_FRAC_BITS  = 24;

   localparam int NUM_LANES = 6;

   // channel order inside one item
   localparam int CH_GYRO_X  = 0;
   localparam int CH_GYRO_Y  = 1;
   localparam int CH_GYRO_Z  = 2;
   localparam int CH_ACCEL_X = 3;
   localparam int CH_ACCEL_Y = 4;
   localparam int CH_ACCEL_Z = 5;

   // accel z starts at 1 g (950 counts), mean square 950^2
   localparam int AZ_MEAN_RESET = 950;
   localparam int AZ_MSQ_RESET  = 950 * 950;

   // register indexes
   localparam logic [2:0] REG_STILL_GYRO_MEAN = 3'd0;
   localparam logic [2:0] REG_STILL_GYRO_DEV  = 3'd1;
   localparam logic [2:0] REG_STILL_ACC_XY    = 3'd2;
   localparam logic [2:0] REG_STILL_ACC_Z_LO  = 3'd3;
   localparam logic [2:0] REG_STILL_ACC_Z_HI  = 3'd4;
   localparam logic [2:0] REG_STILL_ACC_DEV   = 3'd5;
   localparam logic [2:0] REG_DRIVE_GYRO_XY   = 3'd6;
   localparam logic [2:0] REG_DRIVE_ACC_Z     = 3'd7;

   // register reset values
   localparam logic [14:0]        RST_STILL_GYRO_MEAN = 15'd10;
   localparam logic [14:0]        RST_STILL_GYRO_DEV  = 15'd1;
   localparam logic [14:0]        RST_STILL_ACC_XY    = 15'd100;
   localparam logic signed [15:0] RST_STILL_ACC_Z_LO  = 16'sd900;
   localparam logic signed [15:0] RST_STILL_ACC_Z_HI  = 16'sd1000;
   localparam logic [14:0]        RST_STILL_ACC_DEV   = 15'd30;
   localparam logic [14:0]        RST_DRIVE_GYRO_XY   = 15'd100;
   localparam logic signed [15:0] RST_DRIVE_ACC_Z     = 16'sd700;

   // sequencer steps
   localparam logic [2:0] STEP_IDLE  = 3'd0;
   localparam logic [2:0] STEP_SQ    = 3'd1;
   localparam logic [2:0] STEP_MUL_M = 3'd2;
   localparam logic [2:0] STEP_UPD_M = 3'd3;
   localparam logic [2:0] STEP_UPD_Q = 3'd4;
   localparam logic [2:0] STEP_DEV_A = 3'd5;
   localparam logic [2:0] STEP_DEV_B = 3'd6;
   localparam logic [2:0] STEP_OUT   = 3'd7;

   typedef struct packed {
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_z;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } req_type;

   typedef struct packed {
      logic at_rest;
      logic driving_ok;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic [2:0] step;
   } lane_ctl_type;

   typedef struct packed {
      logic signed [16:0] rest_lo;
      logic signed [16:0] rest_hi;
      logic [14:0]        dev_lim;
      logic signed [16:0] drv_lo;
      logic signed [16:0] drv_hi;
      logic               drv_hi_en;
   } lane_cfg_type;

   typedef struct packed {
      logic rest_ok;
      logic drive_ok;
   } lane_res_type;

endpackage

@@ sv/imp_lane.sv @@
`timescale 1ns / 1ps

module imp_lane #(
   parameter int FRAC_BITS  = imp_pkg::DEF_FRAC_BITS,
   parameter int WEIGHT_Q16 = imp_pkg::DEF_WEIGHT_Q16,
   parameter bit Z_RESET    = 1'b0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  imp_pkg::lane_ctl_type ctl,
   input  logic signed [15:0]   sample,
   input  imp_pkg::lane_cfg_type cfg,
   output imp_pkg::lane_res_type res
);
   import imp_pkg::*;

   localparam int MEAN_W = FRAC_BITS + 16;
   localparam int MSQ_W  = FRAC_BITS + 32;
   localparam int DIF_W  = MSQ_W;
   localparam int SPLIT  = DIF_W / 2;
   localparam int HI_W   = DIF_W - SPLIT;
   localparam int SUM_W  = DIF_W + 1;

   localparam logic [15:0] WEIGHT = 16'(WEIGHT_Q16);
   localparam logic signed [MEAN_W-1:0] MEAN_RST =
      Z_RESET ? (MEAN_W'(AZ_MEAN_RESET) << FRAC_BITS) : '0;
   localparam logic signed [MSQ_W-1:0] MSQ_RST =
      Z_RESET ? (MSQ_W'(AZ_MSQ_RESET) << FRAC_BITS) : '0;

   logic signed [15:0]       s_ff;
   logic signed [31:0]       sq_ff;
   logic signed [DIF_W-1:0]  d_ff;
   logic [SPLIT+15:0]        pl_ff;
   logic signed [HI_W+16:0]  ph_ff;
   logic signed [MEAN_W-1:0] mean_ff;
   logic signed [MSQ_W-1:0]  msq_ff;
   logic signed [47:0]       m8sq_ff;
   logic signed [47:0]       q16_ff;
   logic [29:0]              lim2_ff;
   logic                     rest_mean_ff;
   logic                     rest_ff;
   logic                     drv_ff;

   logic signed [DIF_W-1:0]  s_fx;
   logic signed [DIF_W-1:0]  sq_fx;
   logic signed [SUM_W-1:0]  weigh;
   logic signed [23:0]       m8;
   logic signed [MEAN_W:0]   mean_x;
   logic signed [MEAN_W:0]   rest_lo_fx;
   logic signed [MEAN_W:0]   rest_hi_fx;
   logic signed [MEAN_W:0]   drv_lo_fx;
   logic signed [MEAN_W:0]   drv_hi_fx;
   logic signed [48:0]       var_q16;
   logic                     dev_ok;

   assign s_fx  = DIF_W'(s_ff) <<< FRAC_BITS;
   assign sq_fx = DIF_W'(sq_ff) <<< FRAC_BITS;

   // floor(d * w / 2^16), from the two registered partial products
   assign weigh = (SUM_W'(ph_ff) <<< (SPLIT - 16))
                + $signed({{(SUM_W - SPLIT){1'b0}}, pl_ff[SPLIT+15:16]});

   assign m8     = $signed(mean_ff[MEAN_W-1:FRAC_BITS-8]);
   assign mean_x = (MEAN_W + 1)'(mean_ff);
   assign rest_lo_fx = (MEAN_W + 1)'(cfg.rest_lo) <<< FRAC_BITS;
   assign rest_hi_fx = (MEAN_W + 1)'(cfg.rest_hi) <<< FRAC_BITS;
   assign drv_lo_fx  = (MEAN_W + 1)'(cfg.drv_lo) <<< FRAC_BITS;
   assign drv_hi_fx  = (MEAN_W + 1)'(cfg.drv_hi) <<< FRAC_BITS;

   // negative variance clamps to zero, which passes any nonzero limit
   assign var_q16 = 49'(q16_ff) - 49'(m8sq_ff);
   assign dev_ok  = var_q16[48] ? (lim2_ff != '0)
                                : (var_q16[47:0] < {2'b00, lim2_ff, 16'h0000});

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         s_ff <= sample;
      end
      case (ctl.step)
         STEP_SQ: begin
            sq_ff <= s_ff * s_ff;
            d_ff  <= s_fx - DIF_W'(mean_ff);
         end
         STEP_MUL_M, STEP_UPD_M: begin
            pl_ff <= d_ff[SPLIT-1:0] * WEIGHT;
            ph_ff <= $signed(d_ff[DIF_W-1:SPLIT]) * $signed({1'b0, WEIGHT});
            d_ff  <= sq_fx - DIF_W'(msq_ff);
         end
         STEP_DEV_A: begin
            m8sq_ff      <= m8 * m8;
            q16_ff       <= $signed(msq_ff[MSQ_W-1:FRAC_BITS-16]);
            lim2_ff      <= cfg.dev_lim * cfg.dev_lim;
            rest_mean_ff <= (mean_x > rest_lo_fx) && (mean_x < rest_hi_fx);
            drv_ff       <= (mean_x > drv_lo_fx) && (!cfg.drv_hi_en || (mean_x < drv_hi_fx));
         end
         STEP_DEV_B: begin
            rest_ff <= rest_mean_ff && dev_ok;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff <= MEAN_RST;
         msq_ff  <= MSQ_RST;
      end else if (ctl.step == STEP_UPD_M) begin
         mean_ff <= mean_ff + weigh[MEAN_W-1:0];
      end else if (ctl.step == STEP_UPD_Q) begin
         msq_ff <= msq_ff + weigh[MSQ_W-1:0];
      end
   end

   assign res.rest_ok  = rest_ff;
   assign res.drive_ok = drv_ff;

endmodule

@@ sv/imp_merge.sv @@
`timescale 1ns / 1ps

module imp_merge (
   input  logic                                         clock,
   input  logic                                         reset,
   input  imp_pkg::lane_res_type [imp_pkg::NUM_LANES-1:0] lane_res,
   input  logic                                         load,
   output logic                                         free,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output imp_pkg::rsp_type                             rsp_data
);
   import imp_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;
   rsp_type data_in;
   logic    rest_all;

   always_comb begin
      rest_all = 1'b1;
      for (int i = 0; i < NUM_LANES; i++) begin
         rest_all = rest_all & lane_res[i].rest_ok;
      end
   end

   // gyro z and accel x/y do not enter the driving check
   assign data_in.at_rest    = rest_all;
   assign data_in.driving_ok = lane_res[CH_GYRO_X].drive_ok
                             & lane_res[CH_GYRO_Y].drive_ok
                             & lane_res[CH_ACCEL_Z].drive_ok;

   assign free = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

@@ sv/imu_motion_plausibility_check.sv @@
`timescale 1ns / 1ps

// Six-axis IMU plausibility check. Each item is one sample (gyro x/y/z, accel
// x/y/z); every channel keeps an exponential mean and mean square with weight
// WEIGHT_Q16/65536 in FRAC_BITS fixed point, and each item returns two flags:
// at_rest (all means inside their still windows, all variances below the
// squared deviation limits) and driving_ok (gyro x/y means within +/- limit,
// accel z mean above the floor). One lane per channel does the update, and an
// item passes these steps from acceptance to the result register: square and
// difference, the mean product through the lane's split weight multiplier,
// the mean add alongside the mean-square product, the mean-square add, the
// mean^2 product, the variance compare, then the merge into the output
// register. A new item is taken the cycle after a result is loaded, even
// while that result still waits for rsp_ready, but never while an item is still
// in the lanes; a stalled output register holds the sequencer in its last
// step. Limit registers take effect at once and must only be written while
// idle; accel z state resets to 950 counts (1 g).
module imu_motion_plausibility_check #(
   parameter int WEIGHT_Q16 = imp_pkg::DEF_WEIGHT_Q16,
   parameter int FRAC_BITS  = imp_pkg::DEF_FRAC_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  imp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output imp_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_addr,
   input  logic [15:0]      csr_wdata
);
   import imp_pkg::*;

   // limit registers
   logic [14:0]        still_gyro_mean_ff;
   logic [14:0]        still_gyro_dev_ff;
   logic [14:0]        still_acc_xy_ff;
   logic signed [15:0] still_acc_z_lo_ff;
   logic signed [15:0] still_acc_z_hi_ff;
   logic [14:0]        still_acc_dev_ff;
   logic [14:0]        drive_gyro_xy_ff;
   logic signed [15:0] drive_acc_z_ff;

   // sequencer
   logic       busy_ff;
   logic [2:0] step_ff;
   logic       busy_in;
   logic [2:0] step_in;
   logic       accept;
   logic       out_load;
   logic       out_free;

   lane_ctl_type                 lane_ctl;
   lane_cfg_type [NUM_LANES-1:0] lane_cfg;
   lane_res_type [NUM_LANES-1:0] lane_res;
   logic signed [15:0]           sample [NUM_LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         still_gyro_mean_ff <= RST_STILL_GYRO_MEAN;
         still_gyro_dev_ff  <= RST_STILL_GYRO_DEV;
         still_acc_xy_ff    <= RST_STILL_ACC_XY;
         still_acc_z_lo_ff  <= RST_STILL_ACC_Z_LO;
         still_acc_z_hi_ff  <= RST_STILL_ACC_Z_HI;
         still_acc_dev_ff   <= RST_STILL_ACC_DEV;
         drive_gyro_xy_ff   <= RST_DRIVE_GYRO_XY;
         drive_acc_z_ff     <= RST_DRIVE_ACC_Z;
      end else if (csr_we) begin
         case (csr_addr)
            REG_STILL_GYRO_MEAN: still_gyro_mean_ff <= csr_wdata[14:0];
            REG_STILL_GYRO_DEV:  still_gyro_dev_ff  <= csr_wdata[14:0];
            REG_STILL_ACC_XY:    still_acc_xy_ff    <= csr_wdata[14:0];
            REG_STILL_ACC_Z_LO:  still_acc_z_lo_ff  <= $signed(csr_wdata);
            REG_STILL_ACC_Z_HI:  still_acc_z_hi_ff  <= $signed(csr_wdata);
            REG_STILL_ACC_DEV:   still_acc_dev_ff   <= csr_wdata[14:0];
            REG_DRIVE_GYRO_XY:   drive_gyro_xy_ff   <= csr_wdata[14:0];
            REG_DRIVE_ACC_Z:     drive_acc_z_ff     <= $signed(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   // result leaves the lanes only when the output register can take it
   assign out_load  = busy_ff && (step_ff == STEP_OUT) && out_free;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (accept) begin
         busy_in = 1'b1;
         step_in = STEP_SQ;
      end else if (out_load) begin
         busy_in = 1'b0;
         step_in = STEP_IDLE;
      end else if (busy_ff && (step_ff != STEP_OUT)) begin
         step_in = step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_IDLE;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign lane_ctl.load = accept;
   assign lane_ctl.step = step_ff;

   assign sample[CH_GYRO_X]  = req_data.gyro_x;
   assign sample[CH_GYRO_Y]  = req_data.gyro_y;
   assign sample[CH_GYRO_Z]  = req_data.gyro_z;
   assign sample[CH_ACCEL_X] = req_data.accel_x;
   assign sample[CH_ACCEL_Y] = req_data.accel_y;
   assign sample[CH_ACCEL_Z] = req_data.accel_z;

   // per-lane windows; the driving window of the unused lanes is don't-care
   always_comb begin
      for (int i = CH_GYRO_X; i <= CH_GYRO_Z; i++) begin
         lane_cfg[i].rest_lo   = -$signed({2'b00, still_gyro_mean_ff});
         lane_cfg[i].rest_hi   = $signed({2'b00, still_gyro_mean_ff});
         lane_cfg[i].dev_lim   = still_gyro_dev_ff;
         lane_cfg[i].drv_lo    = -$signed({2'b00, drive_gyro_xy_ff});
         lane_cfg[i].drv_hi    = $signed({2'b00, drive_gyro_xy_ff});
         lane_cfg[i].drv_hi_en = 1'b1;
      end
      for (int i = CH_ACCEL_X; i <= CH_ACCEL_Y; i++) begin
         lane_cfg[i].rest_lo   = -$signed({2'b00, still_acc_xy_ff});
         lane_cfg[i].rest_hi   = $signed({2'b00, still_acc_xy_ff});
         lane_cfg[i].dev_lim   = still_acc_dev_ff;
         lane_cfg[i].drv_lo    = '0;
         lane_cfg[i].drv_hi    = '0;
         lane_cfg[i].drv_hi_en = 1'b1;
      end
      lane_cfg[CH_ACCEL_Z].rest_lo   = 17'(still_acc_z_lo_ff);
      lane_cfg[CH_ACCEL_Z].rest_hi   = 17'(still_acc_z_hi_ff);
      lane_cfg[CH_ACCEL_Z].dev_lim   = still_acc_dev_ff;
      lane_cfg[CH_ACCEL_Z].drv_lo    = 17'(drive_acc_z_ff);
      lane_cfg[CH_ACCEL_Z].drv_hi    = '0;
      lane_cfg[CH_ACCEL_Z].drv_hi_en = 1'b0;
   end

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      imp_lane #(
         .FRAC_BITS  (FRAC_BITS),
         .WEIGHT_Q16 (WEIGHT_Q16),
         .Z_RESET    (g == CH_ACCEL_Z)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (lane_ctl),
         .sample (sample[g]),
         .cfg    (lane_cfg[g]),
         .res    (lane_res[g])
      );
   end

   imp_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .lane_res  (lane_res),
      .load      (out_load),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // an accepted item starts the sequence at the first arithmetic step
   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && (step_ff == STEP_SQ))
      else $error("accepted item did not start the step sequence");

   // the step counter only runs while an item is in flight
   a_idle_step : assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (step_ff == STEP_IDLE))
      else $error("step counter moved while idle");

   // a new result only appears after the final step
   a_result_from_out : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(step_ff) == STEP_OUT) && !busy_ff)
      else $error("result loaded outside the output step");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import imp_pkg::*;

   localparam longint WEIGHT = DEF_WEIGHT_Q16;
   localparam int     FRAC   = DEF_FRAC_BITS;
   localparam longint UNIT   = longint'(1) << FRAC;

   localparam int NUM_PHASES      = 9;
   localparam int ITEMS_PER_PHASE = 160;

   localparam logic [2:0] LIMIT_REGS [8] = '{
      REG_STILL_GYRO_MEAN, REG_STILL_GYRO_DEV, REG_STILL_ACC_XY, REG_STILL_ACC_Z_LO,
      REG_STILL_ACC_Z_HI, REG_STILL_ACC_DEV, REG_DRIVE_GYRO_XY, REG_DRIVE_ACC_Z
   };

   // what kind of motion a phase of random items imitates
   typedef enum int {STILL, DRIVING, MIXED} motion_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we    = 1'b0;
   logic [2:0]       csr_addr  = REG_STILL_GYRO_MEAN;
   logic [15:0]      csr_wdata = '0;

   imu_motion_plausibility_check uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Filter mirror: per-channel Q24 mean and mean square, plus a copy of
   // the limit registers as the block sees them after masking.
   // ---------------------------------------------------------------------
   longint run_mean [NUM_LANES];
   longint run_msq  [NUM_LANES];
   longint limit_of [8];

   req_type samples_due [$];   // items waiting for the driver
   rsp_type flags_due   [$];   // predicted flags, oldest first

   // knobs for the current phase, set by the stimulus block
   bit         gaps_on   = 1'b1;
   bit         stalls_on = 1'b1;
   bit         noisy     = 1'b0;
   motion_type phase_mode = STILL;
   int         gyro_span, accel_span, turn_span, z_center;

   int gap_left, stall_left;
   int errors, results_seen, rest_seen, drive_seen;

   // floor(d * w / 2^16), split so the product never overflows
   function automatic longint weighted_step(longint d);
      longint hi, lo;
      hi = d >>> 16;
      lo = d - hi * 65536;
      return hi * WEIGHT + ((lo * WEIGHT) >>> 16);
   endfunction

   // open window on a Q24 mean, limits in whole counts
   function automatic bit in_window(longint m, longint lo, longint hi);
      return m > lo * UNIT && m < hi * UNIT;
   endfunction

   // variance in Q16 from truncated mean (Q8) and mean square (Q16);
   // rounding can push it below zero, which counts as zero
   function automatic bit spread_below(int ch, longint lim);
      longint m8, q16, spread;
      m8     = run_mean[ch] >>> (FRAC - 8);
      q16    = run_msq[ch] >>> (FRAC - 16);
      spread = q16 - m8 * m8;
      if (spread < 0)
         spread = 0;
      return spread < lim * lim * 65536;
   endfunction

   function automatic bit is_signed_reg(logic [2:0] r);
      return r == REG_STILL_ACC_Z_LO || r == REG_STILL_ACC_Z_HI || r == REG_DRIVE_ACC_Z;
   endfunction

   // advance all six filters by one sample and return the two flags
   function automatic rsp_type predict_flags(req_type smp);
      longint  axis [NUM_LANES];
      rsp_type flags;
      bit      rest;
      axis[CH_GYRO_X]  = $signed(smp.gyro_x);
      axis[CH_GYRO_Y]  = $signed(smp.gyro_y);
      axis[CH_GYRO_Z]  = $signed(smp.gyro_z);
      axis[CH_ACCEL_X] = $signed(smp.accel_x);
      axis[CH_ACCEL_Y] = $signed(smp.accel_y);
      axis[CH_ACCEL_Z] = $signed(smp.accel_z);
      for (int ch = 0; ch < NUM_LANES; ch++) begin
         run_mean[ch] += weighted_step(axis[ch] * UNIT - run_mean[ch]);
         run_msq[ch]  += weighted_step(axis[ch] * axis[ch] * UNIT - run_msq[ch]);
      end

      rest = 1'b1;
      for (int ch = CH_GYRO_X; ch <= CH_GYRO_Z; ch++) begin
         rest &= in_window(run_mean[ch], -limit_of[REG_STILL_GYRO_MEAN],
                           limit_of[REG_STILL_GYRO_MEAN]);
         rest &= spread_below(ch, limit_of[REG_STILL_GYRO_DEV]);
      end
      for (int ch = CH_ACCEL_X; ch <= CH_ACCEL_Y; ch++)
         rest &= in_window(run_mean[ch], -limit_of[REG_STILL_ACC_XY],
                           limit_of[REG_STILL_ACC_XY]);
      rest &= in_window(run_mean[CH_ACCEL_Z], limit_of[REG_STILL_ACC_Z_LO],
                        limit_of[REG_STILL_ACC_Z_HI]);
      for (int ch = CH_ACCEL_X; ch <= CH_ACCEL_Z; ch++)
         rest &= spread_below(ch, limit_of[REG_STILL_ACC_DEV]);
      flags.at_rest = rest;

      // gyro z and accel x/y have no say in the driving flag
      flags.driving_ok = in_window(run_mean[CH_GYRO_X], -limit_of[REG_DRIVE_GYRO_XY],
                                   limit_of[REG_DRIVE_GYRO_XY])
                      && in_window(run_mean[CH_GYRO_Y], -limit_of[REG_DRIVE_GYRO_XY],
                                   limit_of[REG_DRIVE_GYRO_XY])
                      && run_mean[CH_ACCEL_Z] > limit_of[REG_DRIVE_ACC_Z] * UNIT;
      return flags;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic int jitter(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // roughly log-uniform in [0, 2^bits), so every scale of limit shows up
   function automatic int log_rand(int bits);
      int k;
      k = $urandom_range(0, bits);
      return (k == 0) ? 0 : int'($urandom_range(0, (1 << k) - 1));
   endfunction

   function automatic req_type pack_sample(int gx, int gy, int gz, int ax, int ay, int az);
      req_type smp;
      smp.gyro_x  = 16'(gx);
      smp.gyro_y  = 16'(gy);
      smp.gyro_z  = 16'(gz);
      smp.accel_x = 16'(ax);
      smp.accel_y = 16'(ay);
      smp.accel_z = 16'(az);
      return smp;
   endfunction

   function automatic req_type draw_sample();
      req_type    smp;
      motion_type kind;
      // rare full-range junk to shake every bit of every field
      if (noisy && $urandom_range(0, 63) == 0) begin
         smp = {$urandom, $urandom, $urandom};
         return smp;
      end
      kind = (phase_mode == MIXED) ? motion_type'($urandom_range(0, 1)) : phase_mode;
      if (kind == STILL)
         return pack_sample(jitter(gyro_span), jitter(gyro_span), jitter(gyro_span),
                            jitter(accel_span), jitter(accel_span),
                            z_center + jitter(accel_span));
      return pack_sample(jitter(turn_span), jitter(turn_span), jitter(4000),
                         jitter(4000), jitter(4000), z_center + jitter(300));
   endfunction

   // register setting per phase: widest, all zero, zero deviation limits,
   // inverted z windows, then random limits of every scale
   function automatic logic [15:0] limit_value(int p, logic [2:0] r);
      if (p == 0)
         return is_signed_reg(r) ? ((r == REG_STILL_ACC_Z_HI) ? 16'h7FFF : 16'h8000)
                                 : 16'hFFFF;   // bit 15 must be dropped
      if (p == 1)
         return 16'h0000;
      if (is_signed_reg(r)) begin
         if (p == 3)
            return (r == REG_STILL_ACC_Z_HI) ? 16'h8000 : 16'h7FFF;
         return (r == REG_STILL_ACC_Z_HI) ? 16'(950 + log_rand(12))
                                          : 16'(950 - log_rand(12));
      end
      if (p == 2 && (r == REG_STILL_GYRO_DEV || r == REG_STILL_ACC_DEV))
         return 16'h8000;   // masks down to a zero limit
      return {1'($urandom_range(0, 1)), 15'(log_rand(15))};
   endfunction

   task automatic set_limit(input logic [2:0] r, input logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= r;
      csr_wdata <= val;
      if (is_signed_reg(r))
         limit_of[r] = longint'($signed(val));
      else
         limit_of[r] = longint'(val[14:0]);
   endtask

   function automatic bit block_busy();
      return samples_due.size() != 0 || req_valid || flags_due.size() != 0;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: feeds items from samples_due, with random idle bursts.
   // Predicts at the edge where the block takes the item.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
         for (int ch = 0; ch < NUM_LANES; ch++) begin
            run_mean[ch] = 0;
            run_msq[ch]  = 0;
         end
         run_mean[CH_ACCEL_Z] = longint'(AZ_MEAN_RESET) * UNIT;
         run_msq[CH_ACCEL_Z]  = longint'(AZ_MSQ_RESET) * UNIT;
         limit_of[REG_STILL_GYRO_MEAN] = RST_STILL_GYRO_MEAN;
         limit_of[REG_STILL_GYRO_DEV]  = RST_STILL_GYRO_DEV;
         limit_of[REG_STILL_ACC_XY]    = RST_STILL_ACC_XY;
         limit_of[REG_STILL_ACC_Z_LO]  = RST_STILL_ACC_Z_LO;
         limit_of[REG_STILL_ACC_Z_HI]  = RST_STILL_ACC_Z_HI;
         limit_of[REG_STILL_ACC_DEV]   = RST_STILL_ACC_DEV;
         limit_of[REG_DRIVE_GYRO_XY]   = RST_DRIVE_GYRO_XY;
         limit_of[REG_DRIVE_ACC_Z]     = RST_DRIVE_ACC_Z;
      end else begin
         if (req_valid && req_ready)
            flags_due.push_back(predict_flags(req_data));
         // slot is free: start a gap, load the next item, or stay idle
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
               gap_left  <= $urandom_range(0, 14);
               req_valid <= 1'b0;
            end else if (samples_due.size() != 0) begin
               req_data  <= samples_due.pop_front();
               req_valid <= 1'b1;
            end else
               req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random stall bursts on rsp_ready, checks each result item
   // against the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (flags_due.size() == 0) begin
               $error("result with no sample outstanding: at_rest %0b driving_ok %0b",
                      rsp_data.at_rest, rsp_data.driving_ok);
               errors++;
            end else begin
               want = flags_due.pop_front();
               results_seen++;
               rest_seen  += want.at_rest;
               drive_seen += want.driving_ok;
               if (rsp_data.at_rest !== want.at_rest) begin
                  $error("at_rest: expected %0b, got %0b (result %0d)",
                         want.at_rest, rsp_data.at_rest, results_seen);
                  errors++;
               end
               if (rsp_data.driving_ok !== want.driving_ok) begin
                  $error("driving_ok: expected %0b, got %0b (result %0d)",
                         want.driving_ok, rsp_data.driving_ok, results_seen);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 14);
            rsp_ready  <= 1'b0;
         end else
            rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus: directed items under reset limits, then phases of random
   // motion, each behind a drain and a fresh set of limit registers.
   // ---------------------------------------------------------------------
   initial begin
      int vals [6];
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      // dead still at 1 g: both flags expected
      repeat (3) samples_due.push_back(pack_sample(0, 0, 0, 0, 0, 950));
      // wild gyro z / accel x,y must not touch driving_ok
      samples_due.push_back(pack_sample(0, 0, -2000, 3000, -3000, 950));
      samples_due.push_back(pack_sample(60, -60, 30000, -30000, 30000, 950));
      // each field alone at both ends of its range
      for (int f = 0; f < 6; f++) begin
         vals = '{0, 0, 0, 0, 0, 950};
         vals[f] = 32767;
         samples_due.push_back(pack_sample(vals[0], vals[1], vals[2],
                                           vals[3], vals[4], vals[5]));
         vals[f] = -32768;
         samples_due.push_back(pack_sample(vals[0], vals[1], vals[2],
                                           vals[3], vals[4], vals[5]));
      end
      samples_due.push_back(pack_sample(32767, 32767, 32767, 32767, 32767, 32767));
      samples_due.push_back(pack_sample(-32768, -32768, -32768, -32768, -32768, -32768));
      samples_due.push_back(pack_sample(-1, -1, -1, -1, -1, -1));

      for (int p = 0; p < NUM_PHASES; p++) begin
         // the sender holds off until every prediction has been matched
         do @(negedge clock); while (block_busy());
         repeat (12) @(posedge clock);
         foreach (LIMIT_REGS[i])
            set_limit(LIMIT_REGS[i], limit_value(p, LIMIT_REGS[i]));
         @(posedge clock);
         csr_we <= 1'b0;

         @(negedge clock);
         phase_mode = motion_type'(p % 3);
         gyro_span  = log_rand(6);
         accel_span = log_rand(7);
         turn_span  = log_rand(9);
         z_center   = 850 + $urandom_range(0, 200);
         noisy      = p < 4;
         // some phases run flat out; the final one has no idling at all
         gaps_on    = p != NUM_PHASES - 1 && p % 3 != 1;
         stalls_on  = p != NUM_PHASES - 1 && p % 3 != 2;
         repeat (ITEMS_PER_PHASE) samples_due.push_back(draw_sample());
      end

      do @(negedge clock); while (block_busy());
      repeat (20) @(posedge clock);
      $display("summary: %0d samples checked over %0d limit settings (widest, zero, inverted,",
               results_seen, NUM_PHASES + 1);
      $display("summary: random); at_rest seen %0d times, driving_ok %0d times",
               rest_seen, drive_seen);
      if (errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   // hard stop, several times the slowest legal run
   initial begin
      #5_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
